### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, masked while reset is held.
`define CHK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check on the rising clock that also covers the reset cycles.
`define CHK_PROP_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/wme_pkg.sv
// Shared types and constants of the windowed mismatch extender.
package wme_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int LENGTH_BITS_DEF = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_LEN     = 2'd0;
    localparam logic [1:0] CFG_MISMATCH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_RUN_NEEDED     = 2'd2;

    // Register reset values.
    localparam logic [6:0] WINDOW_LEN_RST     = 7'd16;
    localparam logic [6:0] MISMATCH_LIMIT_RST = 7'd7;
    localparam logic [7:0] RUN_NEEDED_RST     = 8'd3;

    // Control broadcast from the top level to every window cell.
    typedef struct packed {
        logic step;   // accepted pair while not halted: updates the window
        logic clear;  // last pair: empty the window, slot back to zero
        logic wrap;   // slot pointer sits at or beyond the window length
        logic mm;     // mismatch bit of the current pair
    } t_cell_ctl;

endpackage

### rtl/windowed_mismatch_extender.sv
// A pair's result is registered in the output register, or in the skid entry
// while m_* stalls. One pair per cycle is accepted while s_tready is high; the
// limit is the combinational loop through the window cell row (slot select,
// count update, limit compare). A two-entry output buffer keeps s_tready high
// while one result waits. Reset (synchronous, active low) loads register
// defaults and clears the extension state at once; no clearing pass is needed.
module windowed_mismatch_extender
    import wme_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pair input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [7:0] query_symbol, [15:8] ref_symbol
    input  logic        s_tlast,     // last_pair
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] extent
    output logic        m_tuser,     // [0] halted
    output logic        m_tlast,     // final_res
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int WB = $clog2(MAX_WINDOW + 1);   // holds 0..MAX_WINDOW
    localparam int CW = (WB > 7) ? WB : 7;        // compare width vs 7-bit regs
    localparam int LB = LENGTH_BITS;

    // ---------------- configuration registers ----------------
    logic [6:0] r_window_len;
    logic [6:0] r_mismatch_limit;
    logic [7:0] r_run_needed;
    logic       cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // ---------------- extension state ----------------
    logic [WB-1:0] r_total;
    logic [LB-1:0] r_pair;
    logic [7:0]    r_run;
    logic [LB-1:0] r_best;
    logic          r_stopped;

    logic [WB-1:0] n_total;
    logic [LB-1:0] n_pair;
    logic [7:0]    n_run;
    logic [LB-1:0] n_best;
    logic          n_stopped;

    logic          push;
    logic          mm;
    t_cell_ctl     ctl;
    logic [WB-1:0] win;
    logic [CW-1:0] win_raw;

    logic [MAX_WINDOW-1:0] old_vec;
    logic [MAX_WINDOW-1:0] pass_vec;
    logic [MAX_WINDOW-1:0] wrap_vec;
    logic [MAX_WINDOW-1:0] hi_vec;
    logic                  old_bit;

    assign push = s_tvalid & s_tready;
    assign mm   = (s_tdata[7:0] != s_tdata[15:8]);

    // Window length 0 acts as 1, oversize acts as MAX_WINDOW.
    always_comb begin
        win_raw = CW'(r_window_len);
        if (win_raw == '0) begin
            win = WB'(1);
        end else if (win_raw > CW'(MAX_WINDOW)) begin
            win = WB'(MAX_WINDOW);
        end else begin
            win = WB'(win_raw);
        end
    end

    always_comb begin
        ctl.step  = push & ~r_stopped;
        ctl.clear = push & s_tlast;
        ctl.wrap  = |hi_vec;   // slot left beyond a shortened window
        ctl.mm    = mm;
    end

    // Row of window cells; the slot token walks right and wraps to cell 0.
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic tok_in;
        if (g == 0) begin : g_first
            assign tok_in = |wrap_vec;
        end else begin : g_rest
            assign tok_in = pass_vec[g-1];
        end
        wme_cell #(
            .INDEX (g),
            .WB    (WB)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_win    (win),
            .i_tok_in (tok_in),
            .o_old    (old_vec[g]),
            .o_pass   (pass_vec[g]),
            .o_wrap   (wrap_vec[g]),
            .o_hi     (hi_vec[g])
        );
    end

    assign old_bit = |old_vec;

    // Counters, run tracking and halt decision for the current pair.
    always_comb begin
        n_total   = r_total;
        n_pair    = r_pair;
        n_run     = r_run;
        n_best    = r_best;
        n_stopped = r_stopped;
        if (ctl.step) begin
            n_total = r_total - WB'(old_bit) + WB'(mm);
            n_pair  = (r_pair == '1) ? r_pair : r_pair + LB'(1);
            if (!mm) begin
                n_run = (r_run == 8'hFF) ? r_run : r_run + 8'd1;
                if (n_run >= r_run_needed) begin
                    n_best = n_pair;
                end
            end else begin
                n_run = 8'd0;
            end
            n_stopped = (CW'(n_total) > CW'(r_mismatch_limit));
        end
    end

    // Extent field saturates at 32 bits for wider lengths.
    logic [31:0] ext32;
    if (LB > 32) begin : g_ext_sat
        assign ext32 = (|n_best[LB-1:32]) ? 32'hFFFF_FFFF : n_best[31:0];
    end else begin : g_ext_pad
        assign ext32 = 32'(n_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len     <= WINDOW_LEN_RST;
            r_mismatch_limit <= MISMATCH_LIMIT_RST;
            r_run_needed     <= RUN_NEEDED_RST;
            r_total          <= '0;
            r_pair           <= '0;
            r_run            <= RUN_NEEDED_RST;
            r_best           <= '0;
            r_stopped        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LEN:     r_window_len     <= i_cfg_data[6:0];
                    CFG_MISMATCH_LIMIT: r_mismatch_limit <= i_cfg_data[6:0];
                    CFG_RUN_NEEDED: begin
                        r_run_needed <= i_cfg_data;
                        // fresh extension: run counter follows the new setting
                        if (r_pair == '0) begin
                            r_run <= i_cfg_data;
                        end
                    end
                    default: ;
                endcase
            end
            if (ctl.clear) begin
                r_total   <= '0;
                r_pair    <= '0;
                r_run     <= r_run_needed;
                r_best    <= '0;
                r_stopped <= 1'b0;
            end else if (ctl.step) begin
                r_total   <= n_total;
                r_pair    <= n_pair;
                r_run     <= n_run;
                r_best    <= n_best;
                r_stopped <= n_stopped;
            end
        end
    end

    // ---------------- output register plus skid entry ----------------
    logic        r_out_valid;
    logic [31:0] r_out_ext;
    logic        r_out_halt;
    logic        r_out_last;
    logic        r_skd_valid;
    logic [31:0] r_skd_ext;
    logic        r_skd_halt;
    logic        r_skd_last;
    logic        out_free;

    assign s_tready = ~r_skd_valid;
    assign out_free = ~r_out_valid | m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_skd_valid | push;
                r_skd_valid <= 1'b0;
            end else if (push) begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_valid) begin
                r_out_ext  <= r_skd_ext;
                r_out_halt <= r_skd_halt;
                r_out_last <= r_skd_last;
            end else begin
                r_out_ext  <= ext32;
                r_out_halt <= n_stopped;
                r_out_last <= s_tlast;
            end
        end else if (push) begin
            r_skd_ext  <= ext32;
            r_skd_halt <= n_stopped;
            r_skd_last <= s_tlast;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_ext;
    assign m_tuser  = r_out_halt;
    assign m_tlast  = r_out_last;

endmodule

### rtl/wme_cell.sv
// One slot of the mismatch window: stored bit plus slot-pointer token.
module wme_cell
    import wme_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int WB    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [WB-1:0] i_win,     // clamped window length
    input  logic          i_tok_in,  // token from left neighbor (cell 0: from the wrap)
    output logic          o_old,     // stored bit, when this slot is selected
    output logic          o_pass,    // token moves to right neighbor
    output logic          o_wrap,    // token wraps to cell 0
    output logic          o_hi       // token is beyond the window length
);

    localparam logic [WB-1:0] IDX  = WB'(INDEX);
    localparam logic [WB-1:0] IDX1 = WB'(INDEX + 1);
    localparam logic          IS_FIRST = (INDEX == 0);

    logic r_bit;
    logic r_tok;
    logic n_bit;
    logic n_tok;
    logic sel;

    always_comb begin
        sel    = i_ctl.wrap ? IS_FIRST : r_tok;
        o_old  = sel & r_bit;
        o_pass = sel & (IDX1 < i_win);
        o_wrap = sel & (IDX1 >= i_win);
        o_hi   = r_tok & (IDX >= i_win);
        n_bit  = r_bit;
        n_tok  = r_tok;
        if (i_ctl.clear) begin
            n_bit = 1'b0;
            n_tok = IS_FIRST;
        end else if (i_ctl.step) begin
            n_bit = sel ? i_ctl.mm : r_bit;
            n_tok = i_tok_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
            r_tok <= IS_FIRST;
        end else begin
            r_bit <= n_bit;
            r_tok <= n_tok;
        end
    end

endmodule

### rtl/wme_checker.sv
// Port-level checks on the windowed mismatch extender, bound to the top level.
`include "assert_macros.svh"

module wme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result keeps its payload.
    `CHK_PROP(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}), "stalled result changed")
    // Input back-pressure only while a result is already waiting.
    `CHK_PROP(a_stall_has_result, !s_tready |-> m_tvalid, "s_tready low with no pending result")
    // An accepted pair into an empty output shows up on the next cycle.
    `CHK_PROP(a_one_cycle, s_tvalid && s_tready && !m_tvalid |=> m_tvalid, "result not produced after one cycle")
    // Reset empties the output buffer.
    `CHK_PROP_RST(a_rst_empty, !i_rst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind windowed_mismatch_extender wme_checker u_wme_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/tb_windowed_mismatch_extender.sv
// Self-checking testbench for the windowed mismatch extender: directed and random pair streams.
module tb_windowed_mismatch_extender;
    import wme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_WIN      = MAX_WINDOW_DEF;
    localparam int unsigned RANDOM_ITEMS = 1750;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned STALL_LIMIT  = 2000;   // cycles with no transaction at all
    localparam int unsigned SETTLE_CYC   = 8;      // extra cycles after the last result
    // Index 3 decodes to nothing; writing it must leave every register alone.
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    // One expected result transaction.
    typedef struct {
        bit [31:0] extent;
        bit        halted;
        bit        final_res;
    } t_ext_result;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [7:0] query_symbol, [15:8] ref_symbol
    logic        s_tlast     = 1'b0; // last_pair
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;            // [31:0] extent
    logic        m_tuser;            // [0] halted
    logic        m_tlast;            // final_res
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;

    windowed_mismatch_extender dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: register copies and the extension in progress.
    // ------------------------------------------------------------------
    bit [6:0]          win_reg;
    bit [6:0]          limit_reg;
    bit [7:0]          run_reg;
    bit [MAX_WIN-1:0]  mm_bits;
    int unsigned       slot_ptr;
    int unsigned       mm_count;
    bit [31:0]         pairs_seen;
    int unsigned       run_len;
    bit [31:0]         best_ext;
    bit                halted_now;

    t_ext_result       expected_extents[$];
    int unsigned       mismatch_cnt = 0;
    bit                idle_on      = 1'b1;  // random gaps on both sides when set

    // Drop the extension: window empty, counters zero, run reloaded.
    function automatic void clear_extension();
        mm_bits    = '0;
        slot_ptr   = 0;
        mm_count   = 0;
        pairs_seen = '0;
        run_len    = 32'(run_reg);
        best_ext   = '0;
        halted_now = 1'b0;
    endfunction

    function automatic void apply_reg(logic [1:0] idx, bit [7:0] val);
        case (idx)
            CFG_WINDOW_LEN: begin
                win_reg = val[6:0];
            end
            CFG_MISMATCH_LIMIT: begin
                limit_reg = val[6:0];
            end
            CFG_RUN_NEEDED: begin
                run_reg = val;
                // Fresh extension: run counter follows the new requirement at once.
                if (pairs_seen == 0)
                    run_len = 32'(val);
            end
            default: begin
            end
        endcase
    endfunction

    // Advance the extension by one pair and return the result it produces.
    function automatic t_ext_result extend_pair(bit [7:0] q, bit [7:0] r, bit last);
        int unsigned w;
        bit          mm;
        t_ext_result res;
        if (!halted_now) begin
            w = 32'(win_reg);
            if (w < 1)
                w = 1;
            if (w > MAX_WIN)
                w = MAX_WIN;
            // Shrunken window: pointer past the end restarts at slot zero.
            if (slot_ptr >= w)
                slot_ptr = 0;
            mm = (q != r);
            mm_count = mm_count - mm_bits[slot_ptr] + mm;
            mm_bits[slot_ptr] = mm;
            slot_ptr = (slot_ptr + 1 >= w) ? 0 : slot_ptr + 1;
            if (pairs_seen != '1)
                pairs_seen++;
            if (!mm) begin
                if (run_len < 255)
                    run_len++;
                if (run_len >= run_reg)
                    best_ext = pairs_seen;
            end else begin
                run_len = 0;
            end
            if (mm_count > limit_reg)
                halted_now = 1'b1;
        end
        res.extent    = best_ext;
        res.halted    = halted_now;
        res.final_res = last;
        if (last)
            clear_extension();
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
        mismatch_cnt++;
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp);
    endtask

    // Hold the pair stream off until every outstanding result has come back.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_extents.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; the block is drained first so the write lands while idle.
    task automatic write_reg(logic [1:0] idx, bit [7:0] val);
        wait_results_done();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        apply_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(bit [7:0] w, bit [7:0] lim, bit [7:0] run);
        write_reg(CFG_WINDOW_LEN, w);
        write_reg(CFG_MISMATCH_LIMIT, lim);
        write_reg(CFG_RUN_NEEDED, run);
    endtask

    // Send one pair; tvalid stays up after the transaction so back-to-back
    // pairs never see it dropped and raised in the same step.
    task automatic send_pair(bit [7:0] q, bit [7:0] r, bit last);
        while (idle_on && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, q};
        s_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_tready);
        expected_extents.push_back(extend_pair(q, r, last));
    endtask

    // Random extension of len pairs, mismatching about pct percent of the time.
    task automatic send_extension(int unsigned len, int unsigned pct);
        int          cut;
        bit [7:0]    q;
        bit [7:0]    r;
        bit [7:0]    v;
        cut = -1;
        if (len > 1 && $urandom_range(7) == 0)
            cut = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++) begin
            if (i == cut) begin
                // Mid-extension register change while the block is idle.
                case ($urandom_range(2))
                    0: begin
                        v = 8'($urandom_range(0, 70));
                        write_reg(CFG_WINDOW_LEN, v);
                    end
                    1: begin
                        v = 8'($urandom_range(0, 64));
                        write_reg(CFG_MISMATCH_LIMIT, v);
                    end
                    default: begin
                        v = 8'($urandom_range(0, 8));
                        write_reg(CFG_RUN_NEEDED, v);
                    end
                endcase
            end
            q = 8'($urandom_range(0, 255));
            if ($urandom_range(99) < pct)
                r = q ^ 8'($urandom_range(1, 255));
            else if ($urandom_range(19) == 0)
                r = 8'($urandom_range(0, 255));   // noise
            else
                r = q;
            send_pair(q, r, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and field-by-field comparison.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ext_result exp_res;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_extents.size() == 0) begin
                report_mismatch("unexpected result, extent", m_tdata, 0);
            end else begin
                exp_res = expected_extents.pop_front();
                if (m_tdata !== exp_res.extent)
                    report_mismatch("extent", m_tdata, exp_res.extent);
                if (m_tuser !== exp_res.halted)
                    report_mismatch("halted", m_tuser, exp_res.halted);
                if (m_tlast !== exp_res.final_res)
                    report_mismatch("final_res", m_tlast, exp_res.final_res);
            end
        end
        m_tready <= !idle_on || ($urandom_range(99) >= 32);
    end

    // Watchdog: too long without any transaction on any channel ends the run.
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("windowed_mismatch_extender: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    // Register defaults straight out of reset: window 16, limit 7, run 3.
    task automatic test_reset_defaults();
        send_pair(8'h11, 8'h11, 1'b0);
        send_pair(8'h11, 8'h12, 1'b0);
        send_pair(8'h40, 8'h40, 1'b0);
        send_pair(8'h41, 8'h41, 1'b1);
    endtask

    // Symbol extremes, single-pair extensions included.
    task automatic test_symbol_extremes();
        set_regs(8'd16, 8'd7, 8'd1);
        send_pair(8'h00, 8'h00, 1'b1);
        send_pair(8'hFF, 8'hFF, 1'b1);
        send_pair(8'h00, 8'hFF, 1'b0);
        send_pair(8'hFF, 8'h00, 1'b1);
    endtask

    // Write to the undecoded index; behavior must not change.
    task automatic test_unused_index();
        write_reg(CFG_UNUSED, 8'hFF);
        send_pair(8'h5A, 8'hA5, 1'b1);
    endtask

    // Limit zero halts on the first mismatch; later pairs hold the extent.
    task automatic test_halt_ignores_pairs();
        set_regs(8'd16, 8'd0, 8'd1);
        send_pair(8'h01, 8'h01, 1'b0);
        send_pair(8'h01, 8'h02, 1'b0);
        send_pair(8'h03, 8'h03, 1'b0);
        send_pair(8'h04, 8'h04, 1'b1);
    endtask

    // Window length zero acts as one; above the maximum acts as the maximum.
    task automatic test_window_clamp();
        set_regs(8'd0, 8'd1, 8'd1);
        send_pair(8'h10, 8'h20, 1'b0);
        send_pair(8'h10, 8'h20, 1'b0);
        send_pair(8'h30, 8'h30, 1'b1);
        set_regs(8'hFF, 8'd1, 8'd1);
        send_pair(8'h10, 8'h20, 1'b0);
        send_pair(8'h30, 8'h30, 1'b0);
        send_pair(8'h10, 8'h20, 1'b1);
    endtask

    // Shrink the window mid-extension: slot wraps, stored bits still count.
    task automatic test_window_shrink_mid();
        set_regs(8'd4, 8'd2, 8'd1);
        send_pair(8'h01, 8'h02, 1'b0);
        send_pair(8'h01, 8'h02, 1'b0);
        write_reg(CFG_WINDOW_LEN, 8'd2);
        send_pair(8'h01, 8'h02, 1'b0);
        send_pair(8'h07, 8'h07, 1'b1);
    endtask

    // Run requirement zero, and run writes with and without pairs taken.
    task automatic test_run_reload();
        set_regs(8'd16, 8'd7, 8'd0);
        send_pair(8'h01, 8'h02, 1'b0);
        send_pair(8'h03, 8'h03, 1'b1);
        write_reg(CFG_RUN_NEEDED, 8'd4);
        send_pair(8'h03, 8'h03, 1'b0);
        write_reg(CFG_RUN_NEEDED, 8'd1);
        send_pair(8'h03, 8'h03, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random extensions over a sequence of register settings.
    // ------------------------------------------------------------------
    task automatic test_random_extensions();
        int unsigned phase;
        int unsigned sent_total;
        int unsigned sent_phase;
        int unsigned len;
        int unsigned pct;
        int unsigned w_eff;
        bit [7:0]    wv;
        bit [7:0]    lv;
        bit [7:0]    rv;
        phase      = 0;
        sent_total = 0;
        while (sent_total < RANDOM_ITEMS) begin
            case (phase)
                0: begin wv = 8'd1;   lv = 8'd0;  rv = 8'd1;   end
                1: begin wv = 8'd64;  lv = 8'd64; rv = 8'd255; end
                2: begin wv = 8'd0;   lv = 8'd1;  rv = 8'd0;   end
                3: begin wv = 8'hFF;  lv = 8'hFF; rv = 8'd3;   end
                4: begin wv = 8'd64;  lv = 8'd2;  rv = 8'd255; end
                default: begin
                    wv = ($urandom_range(4) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 64));
                    w_eff = (wv[6:0] == 0) ? 1 : (wv[6:0] > MAX_WIN) ? MAX_WIN : wv[6:0];
                    lv = ($urandom_range(7) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, w_eff));
                    rv = ($urandom_range(5) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 6));
                end
            endcase
            // One phase runs with both sides streaming flat out.
            idle_on = (phase != 6);
            set_regs(wv, lv, rv);
            sent_phase = 0;
            while (sent_phase < PHASE_ITEMS && sent_total < RANDOM_ITEMS) begin
                if (run_reg > 16 || $urandom_range(9) == 0)
                    len = $urandom_range(200, 320);
                else
                    len = $urandom_range(1, 40);
                // Keep the total pair count on budget.
                if (len > RANDOM_ITEMS - sent_total)
                    len = RANDOM_ITEMS - sent_total;
                case ($urandom_range(5))
                    0: pct = 0;
                    1: pct = 1;
                    2: pct = 5;
                    3: pct = 15;
                    4: pct = 40;
                    default: pct = 100;
                endcase
                send_extension(len, pct);
                sent_phase += len;
                sent_total += len;
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        win_reg   = WINDOW_LEN_RST;
        limit_reg = MISMATCH_LIMIT_RST;
        run_reg   = RUN_NEEDED_RST;
        clear_extension();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_symbol_extremes();
        test_unused_index();
        test_halt_ignores_pairs();
        test_window_clamp();
        test_window_shrink_mid();
        test_run_reload();
        test_random_extensions();

        // Drain, then let the clock run on so the output buffer can show any stray result.
        wait_results_done();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_extents.size() == 0) begin
            $display("windowed_mismatch_extender: match");
        end else begin
            $display("windowed_mismatch_extender: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/wme_pkg.sv
rtl/wme_cell.sv
rtl/windowed_mismatch_extender.sv
rtl/wme_checker.sv
tb/tb_windowed_mismatch_extender.sv
